// ===== rtl/fpr_pkg.sv =====
// ----------------------------------------------------------------------------
// FIFO page replacement package
// Shared widths, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package fpr_pkg;

   localparam int MEM_REF_W    = 31;
   localparam int PAGE_BYTES_W = 17;
   localparam int FRAMES_W     = 5;
   localparam int COUNT_W      = 32;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;
   localparam int STEP_W       = 5;

   localparam logic [FRAMES_W-1:0]     FRAMES_RESET     = 5'd16;
   localparam logic [PAGE_BYTES_W-1:0] PAGE_BYTES_RESET = 17'd4096;

   localparam logic CSR_FRAMES_IN_USE = 1'b0;
   localparam logic CSR_PAGE_BYTES    = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_COMPARE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/fpr_divider.sv =====
// ----------------------------------------------------------------------------
// FIFO page replacement divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_divider (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [fpr_pkg::MEM_REF_W-1:0]      dividend,
   input  wire logic [fpr_pkg::PAGE_BYTES_W-1:0]   divisor,
   output logic                                    done,
   output logic [fpr_pkg::MEM_REF_W-1:0]           quotient
);

   localparam int QW = fpr_pkg::MEM_REF_W;
   localparam int DW = fpr_pkg::PAGE_BYTES_W;

   logic [DW-1:0]                rem_ff, rem_in;
   logic [QW-1:0]                quo_ff, quo_in;
   logic [DW-1:0]                div_ff, div_in;
   logic [fpr_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                         run_ff, run_in;
   logic                         done_ff, done_in;
   logic [DW:0]                  trial;
   logic                         fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[QW-1]};
      fits    = trial >= {1'b0, div_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = (divisor == '0) ? DW'(1) : divisor;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         rem_in  = fits ? DW'(trial - {1'b0, div_ff}) : trial[DW-1:0];
         quo_in  = {quo_ff[QW-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == fpr_pkg::STEP_W'(QW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/fifo_page_replacement.sv =====
// ----------------------------------------------------------------------------
// FIFO page replacement unit
// Converts each memory reference to a page number and keeps a FIFO table of
// resident pages, reporting faults and a running fault count.
//
// Usage: a reference beat is taken when start is high and busy is low. The
// reference is divided by the page size in a bit-serial divider, and the
// frame table memory is then searched one frame at a time, with a registered
// read followed by a compare. A hit ends the search at its frame; a miss
// searches every frame of the ring. Busy stays high until the result cycle,
// so one reference is in flight at a time. Each result beat is shown for one
// cycle with rsp_valid high and the receiver cannot stall it. Reset empties
// the table, zeroes the fault count and restores the registers to 16 frames
// and 4096-byte pages. Writing the frame count empties the table; the user
// is bound to write the configuration port only while the unit is idle, and
// the unit itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_page_replacement #(
   parameter int MAX_FRAMES = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [fpr_pkg::MEM_REF_W-1:0]       req_mem_ref,
   output logic                                     rsp_valid,
   output logic [fpr_pkg::MEM_REF_W-1:0]            rsp_page_num,
   output logic                                     rsp_fault,
   output logic [fpr_pkg::COUNT_W-1:0]              rsp_fault_total,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [fpr_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [fpr_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [fpr_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                     csr_pready
);

   localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int PW    = fpr_pkg::MEM_REF_W;

   fpr_pkg::state_type                  state_ff, state_in;
   logic [fpr_pkg::FRAMES_W-1:0]        frames_ff;
   logic [fpr_pkg::PAGE_BYTES_W-1:0]    page_bytes_ff;
   logic [fpr_pkg::COUNT_W-1:0]         fault_count_ff;
   logic [IDX_W-1:0]                    ptr_ff;
   logic [MAX_FRAMES-1:0]               valid_ff;
   logic [IDX_W-1:0]                    idx_ff, idx_in;
   logic [PW-1:0]                       page_ff, page_in;
   logic [PW-1:0]                       frame_page [MAX_FRAMES];
   logic [PW-1:0]                       rd_data_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_fault_ff, rsp_fault_in;
   logic                                div_start;
   logic                                div_done;
   logic [PW-1:0]                       div_quotient;
   logic                                csr_write;
   logic                                miss;
   logic                                hit_now;
   logic                                last_frame;
   logic [CNT_W-1:0]                    ring_n;
   logic [IDX_W-1:0]                    slot;
   logic [CNT_W-1:0]                    slot_next;

   fpr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_mem_ref),
      .divisor  (page_bytes_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_paddr[2])
         fpr_pkg::CSR_FRAMES_IN_USE: csr_prdata = fpr_pkg::CSR_DATA_W'(frames_ff);
         fpr_pkg::CSR_PAGE_BYTES:    csr_prdata = fpr_pkg::CSR_DATA_W'(page_bytes_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (frames_ff == '0) begin
         ring_n = CNT_W'(1);
      end else if (32'(frames_ff) > 32'(MAX_FRAMES)) begin
         ring_n = CNT_W'(MAX_FRAMES);
      end else begin
         ring_n = CNT_W'(frames_ff);
      end
      slot      = (CNT_W'(ptr_ff) < ring_n) ? ptr_ff : '0;
      slot_next = CNT_W'(slot) + CNT_W'(1);
   end

   assign hit_now    = valid_ff[idx_ff] && (rd_data_ff == page_ff);
   assign last_frame = (CNT_W'(idx_ff) + CNT_W'(1)) == ring_n;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      page_in      = page_ff;
      div_start    = 1'b0;
      miss         = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_fault_in = 1'b0;
      unique case (state_ff)
         fpr_pkg::ST_IDLE: begin
            if (start) begin
               div_start = 1'b1;
               state_in  = fpr_pkg::ST_DIVIDE;
            end
         end
         fpr_pkg::ST_DIVIDE: begin
            if (div_done) begin
               page_in  = div_quotient;
               idx_in   = '0;
               state_in = fpr_pkg::ST_READ;
            end
         end
         fpr_pkg::ST_READ: begin
            state_in = fpr_pkg::ST_COMPARE;
         end
         fpr_pkg::ST_COMPARE: begin
            priority if (hit_now) begin
               rsp_valid_in = 1'b1;
               state_in     = fpr_pkg::ST_IDLE;
            end else if (last_frame) begin
               miss         = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_fault_in = 1'b1;
               state_in     = fpr_pkg::ST_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = fpr_pkg::ST_READ;
            end
         end
         default: begin
            state_in = fpr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= fpr_pkg::ST_IDLE;
         frames_ff      <= fpr_pkg::FRAMES_RESET;
         page_bytes_ff  <= fpr_pkg::PAGE_BYTES_RESET;
         fault_count_ff <= '0;
         ptr_ff         <= '0;
         valid_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         priority if (csr_write && (csr_paddr[2] == fpr_pkg::CSR_FRAMES_IN_USE)) begin
            frames_ff <= csr_pwdata[fpr_pkg::FRAMES_W-1:0];
            valid_ff  <= '0;
            ptr_ff    <= '0;
         end else if (csr_write && (csr_paddr[2] == fpr_pkg::CSR_PAGE_BYTES)) begin
            page_bytes_ff <= csr_pwdata[fpr_pkg::PAGE_BYTES_W-1:0];
         end else if (miss) begin
            fault_count_ff <= fault_count_ff + 1'b1;
            valid_ff[slot] <= 1'b1;
            ptr_ff         <= (slot_next >= ring_n) ? '0 : IDX_W'(slot_next);
         end
      end
      idx_ff       <= idx_in;
      page_ff      <= page_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   always_ff @(posedge clock) begin
      if (miss) begin
         frame_page[slot] <= page_ff;
      end
      rd_data_ff <= frame_page[idx_ff];
   end

   assign busy            = (state_ff != fpr_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_page_num    = page_ff;
   assign rsp_fault       = rsp_fault_ff;
   assign rsp_fault_total = fault_count_ff;

`ifndef SYNTHESIS
   a_rsp_after_compare: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == fpr_pkg::ST_COMPARE)
      else $error("result beat without a compare step");

   a_ptr_in_ring: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(ptr_ff) < ring_n)
      else $error("insert pointer outside the ring");

   a_fault_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fault_ff |-> fault_count_ff == $past(fault_count_ff) + 1'b1)
      else $error("fault beat without a fault count increment");

   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == fpr_pkg::ST_IDLE)
      else $error("unit busy during its result beat");
`endif

endmodule

`default_nettype wire
